/* hw/rtl/gtu_pkg.sv */
// Shared types and constants for the GPS week/time to UTC calendar date converter.
`timescale 1ns / 1ps

package gtu_pkg;

    // Request and result payloads
    typedef struct packed {
        logic [15:0] gps_week;
        logic [31:0] week_time_ms;
    } gtu_req_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } gtu_rsp_t;

    // Reciprocals for constant division, scaled by 2^k; the two exact ones are
    // rounded up, the rest are rounded down and fixed by a remainder compare
    localparam logic [28:0] MS_RECIP    = 29'd274877907; // 1/1000, k = 38, exact for 32 bits
    localparam logic [15:0] DAY_RECIP   = 16'd49711;     // 1/675, k = 25, exact for 16 bits
    localparam logic [14:0] CENT_RECIP  = 15'd29398;     // 1/146097, k = 32
    localparam logic [23:0] YEAR_RECIP  = 24'd11758971;  // 4000/1461001, k = 32
    localparam logic [10:0] HOUR_RECIP  = 11'd1165;      // 1/3600, k = 22
    localparam logic [10:0] MIN_RECIP   = 11'd1092;      // 1/60, k = 16
    localparam logic [11:0] MONTH_RECIP = 12'd2142;      // 80/2447, k = 16

    // Calendar constants
    localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
    localparam logic [21:0] JD_AT_GPS_EPOCH = 22'd2512814; // MJD 44244 plus 2468570
    localparam logic [17:0] DAYS_PER_400Y   = 18'd146097;
    localparam logic [20:0] YEAR_DIVISOR    = 21'd1461001;
    localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
    localparam logic [6:0]  SECS_PER_MIN    = 7'd60;
    localparam logic [11:0] MONTH_DIVISOR   = 12'd2447;
    localparam logic [10:0] DAYS_PER_4Y     = 11'd1461;

    // Day offset of a month index: floor(2447 * m / 80)
    function automatic logic [8:0] month_day_ofs(input logic [3:0] m);
        logic [8:0] ofs;
        begin
            case (m)
                4'd0:    ofs = 9'd0;
                4'd1:    ofs = 9'd30;
                4'd2:    ofs = 9'd61;
                4'd3:    ofs = 9'd91;
                4'd4:    ofs = 9'd122;
                4'd5:    ofs = 9'd152;
                4'd6:    ofs = 9'd183;
                4'd7:    ofs = 9'd214;
                4'd8:    ofs = 9'd244;
                4'd9:    ofs = 9'd275;
                4'd10:   ofs = 9'd305;
                4'd11:   ofs = 9'd336;
                4'd12:   ofs = 9'd367;
                4'd13:   ofs = 9'd397;
                4'd14:   ofs = 9'd428;
                default: ofs = 9'd458;
            endcase
            return ofs;
        end
    endfunction

endpackage

/* hw/rtl/gps_time_to_utc_date.sv */
// Top level: pipelined conversion of GPS week and time of week to calendar date and time of day.
`timescale 1ns / 1ps

// A request is taken on every clock edge where start is high; busy is always low, so one
// request per cycle is sustained. Each request gives exactly one result, shown on result
// for one cycle with done high; the receiver cannot stall it. The pipeline depth is set
// by the chain of reciprocal multiplications; each inexact one is followed by a remainder
// stage and a correction stage. Leap seconds and week rollover are not applied; milliseconds
// are truncated and whole days beyond one week carry into the date.
module gps_time_to_utc_date (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  gtu_pkg::gtu_req_t request,
    output logic              done,
    output gtu_pkg::gtu_rsp_t result
);
    import gtu_pkg::*;

    localparam int NUM_STAGES = 14;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } hms_t;

    // Valid bits travel alongside the data
    logic [NUM_STAGES-1:0] vld_reg, vld_next;

    // Stage 1: seconds of week
    logic [15:0] s1_week_reg, s1_week_next;
    logic [22:0] s1_secs_reg, s1_secs_next;
    // Stage 2: whole days in time of week
    logic [15:0] s2_week_reg;
    logic [22:0] s2_secs_reg;
    logic [5:0]  s2_dq_reg, s2_dq_next;
    // Stage 3: Julian day and time of day
    logic [21:0] s3_j0_reg, s3_j0_next;
    logic [16:0] s3_tod_reg, s3_tod_next;
    // Stage 4: century and hour estimates
    logic [21:0] s4_j0_reg;
    logic [6:0]  s4_cest_reg, s4_cest_next;
    logic [16:0] s4_tod_reg;
    logic [4:0]  s4_hest_reg, s4_hest_next;
    // Stage 5: remainders
    logic [6:0]  s5_cest_reg;
    logic [18:0] s5_cr_reg, s5_cr_next;
    logic [4:0]  s5_hest_reg;
    logic [12:0] s5_hr_reg, s5_hr_next;
    // Stage 6: corrected century and hour
    logic [6:0]  s6_c_reg, s6_c_next;
    logic [15:0] s6_j1_reg, s6_j1_next;
    logic [4:0]  s6_hour_reg, s6_hour_next;
    logic [11:0] s6_remh_reg, s6_remh_next;
    // Stage 7: year and minute estimates
    logic [6:0]  s7_c_reg;
    logic [15:0] s7_j1_reg;
    logic [6:0]  s7_yest_reg, s7_yest_next;
    logic [4:0]  s7_hour_reg;
    logic [11:0] s7_remh_reg;
    logic [5:0]  s7_mest_reg, s7_mest_next;
    // Stage 8: remainders
    logic [6:0]  s8_c_reg;
    logic [15:0] s8_j1_reg;
    logic [6:0]  s8_yest_reg;
    logic [21:0] s8_yr_reg, s8_yr_next;
    logic [4:0]  s8_hour_reg;
    logic [6:0]  s8_sr_reg, s8_sr_next;
    logic [5:0]  s8_mest_reg;
    // Stage 9: corrected year in cycle, minute and second
    logic [6:0]  s9_c_reg;
    logic [15:0] s9_j1_reg;
    logic [6:0]  s9_y_reg, s9_y_next;
    hms_t        s9_hms_reg, s9_hms_next;
    // Stage 10: day within March-based year
    logic [6:0]  s10_c_reg;
    logic [6:0]  s10_y_reg;
    logic [8:0]  s10_j2_reg, s10_j2_next;
    hms_t        s10_hms_reg;
    // Stage 11: month estimate
    logic [6:0]  s11_c_reg;
    logic [6:0]  s11_y_reg;
    logic [8:0]  s11_j2_reg;
    logic [3:0]  s11_mest_reg, s11_mest_next;
    hms_t        s11_hms_reg;
    // Stage 12: month remainder
    logic [6:0]  s12_c_reg;
    logic [6:0]  s12_y_reg;
    logic [8:0]  s12_j2_reg;
    logic [3:0]  s12_mest_reg;
    logic [12:0] s12_mr_reg, s12_mr_next;
    hms_t        s12_hms_reg;
    // Stage 13: corrected month index
    logic [6:0]  s13_c_reg;
    logic [6:0]  s13_y_reg;
    logic [8:0]  s13_j2_reg;
    logic [3:0]  s13_m_reg, s13_m_next;
    hms_t        s13_hms_reg;
    // Stage 14: result
    gtu_rsp_t    rsp_reg, rsp_next;

    // Products of the reciprocal multiplications
    logic [60:0] ms_prod;
    logic [31:0] day_prod;
    logic [38:0] cent_prod;
    logic [27:0] hour_prod;
    logic [40:0] year_prod;
    logic [22:0] min_prod;
    logic [20:0] month_prod;

    // Intermediate values
    logic [22:0] dq_secs;
    logic [23:0] cent_x;
    logic [23:0] cent_rem;
    logic [16:0] hour_rem;
    logic [18:0] cr_adj;
    logic [16:0] year_x;
    logic [27:0] year_rem;
    logic [11:0] min_rem;
    logic [6:0]  sr_adj;
    logic [17:0] four_year_days;
    logic [15:0] j2_full;
    logic [14:0] month_rem;
    logic [8:0]  dd_full;
    logic        k_carry;
    logic [11:0] yy_full;

    assign busy = 1'b0;
    assign done = vld_reg[NUM_STAGES-1];
    assign result = rsp_reg;

    // Advance the valid bits
    assign vld_next = {vld_reg[NUM_STAGES-2:0], start};

    // Stage 1: truncate milliseconds to seconds
    always_comb
    begin
        ms_prod      = 61'(request.week_time_ms) * 61'(MS_RECIP);
        s1_secs_next = ms_prod[60:38];
        s1_week_next = request.gps_week;
    end

    // Stage 2: split off whole days; divide by 128 then by 675
    always_comb
    begin
        day_prod   = 32'(s1_secs_reg[22:7]) * 32'(DAY_RECIP);
        s2_dq_next = day_prod[30:25];
    end

    // Stage 3: time of day and Julian day number
    always_comb
    begin
        dq_secs     = 23'(s2_dq_reg) * 23'(SECS_PER_DAY);
        s3_tod_next = 17'(s2_secs_reg - dq_secs);
        s3_j0_next  = 22'(s2_week_reg) * 22'd7 + 22'(s2_dq_reg) + JD_AT_GPS_EPOCH;
    end

    // Stage 4: estimate century and hour
    always_comb
    begin
        cent_x       = {s3_j0_reg, 2'b00};
        cent_prod    = 39'(cent_x) * 39'(CENT_RECIP);
        s4_cest_next = cent_prod[38:32];
        hour_prod    = 28'(s3_tod_reg) * 28'(HOUR_RECIP);
        s4_hest_next = hour_prod[26:22];
    end

    // Stage 5: remainders of the estimates
    always_comb
    begin
        cent_rem   = {s4_j0_reg, 2'b00} - 24'(s4_cest_reg) * 24'(DAYS_PER_400Y);
        s5_cr_next = cent_rem[18:0];
        hour_rem   = s4_tod_reg - 17'(s4_hest_reg) * 17'(SECS_PER_HOUR);
        s5_hr_next = hour_rem[12:0];
    end

    // Stage 6: correct estimates that fell one short
    always_comb
    begin
        if (s5_cr_reg >= 19'(DAYS_PER_400Y))
        begin
            s6_c_next = s5_cest_reg + 7'd1;
            cr_adj    = s5_cr_reg - 19'(DAYS_PER_400Y);
        end
        else
        begin
            s6_c_next = s5_cest_reg;
            cr_adj    = s5_cr_reg;
        end
        s6_j1_next = cr_adj[17:2];

        if (s5_hr_reg >= 13'(SECS_PER_HOUR))
        begin
            s6_hour_next = s5_hest_reg + 5'd1;
            s6_remh_next = 12'(s5_hr_reg - 13'(SECS_PER_HOUR));
        end
        else
        begin
            s6_hour_next = s5_hest_reg;
            s6_remh_next = s5_hr_reg[11:0];
        end
    end

    // Stage 7: estimate year in cycle and minute
    always_comb
    begin
        year_x       = 17'(s6_j1_reg) + 17'd1;
        year_prod    = 41'(year_x) * 41'(YEAR_RECIP);
        s7_yest_next = year_prod[38:32];
        min_prod     = 23'(s6_remh_reg) * 23'(MIN_RECIP);
        s7_mest_next = min_prod[21:16];
    end

    // Stage 8: remainders of the estimates
    always_comb
    begin
        year_rem   = (28'(s7_j1_reg) + 28'd1) * 28'd4000
                     - 28'(s7_yest_reg) * 28'(YEAR_DIVISOR);
        s8_yr_next = year_rem[21:0];
        min_rem    = s7_remh_reg - 12'(s7_mest_reg) * 12'(SECS_PER_MIN);
        s8_sr_next = min_rem[6:0];
    end

    // Stage 9: correct year, minute and second
    always_comb
    begin
        if (s8_yr_reg >= 22'(YEAR_DIVISOR))
        begin
            s9_y_next = s8_yest_reg + 7'd1;
        end
        else
        begin
            s9_y_next = s8_yest_reg;
        end

        s9_hms_next.hour = s8_hour_reg;
        if (s8_sr_reg >= SECS_PER_MIN)
        begin
            s9_hms_next.minute = s8_mest_reg + 6'd1;
            sr_adj             = s8_sr_reg - SECS_PER_MIN;
        end
        else
        begin
            s9_hms_next.minute = s8_mest_reg;
            sr_adj             = s8_sr_reg;
        end
        s9_hms_next.second = sr_adj[5:0];
    end

    // Stage 10: day count from March 1 of the year, plus 31
    always_comb
    begin
        four_year_days = 18'(s9_y_reg) * 18'(DAYS_PER_4Y);
        j2_full        = s9_j1_reg - 16'(four_year_days >> 2) + 16'd31;
        s10_j2_next    = j2_full[8:0];
    end

    // Stage 11: estimate month index
    always_comb
    begin
        month_prod    = 21'(s10_j2_reg) * 21'(MONTH_RECIP);
        s11_mest_next = month_prod[19:16];
    end

    // Stage 12: month remainder
    always_comb
    begin
        month_rem   = 15'(s11_j2_reg) * 15'd80 - 15'(s11_mest_reg) * 15'(MONTH_DIVISOR);
        s12_mr_next = month_rem[12:0];
    end

    // Stage 13: correct month index
    always_comb
    begin
        if (s12_mr_reg >= 13'(MONTH_DIVISOR))
        begin
            s13_m_next = s12_mest_reg + 4'd1;
        end
        else
        begin
            s13_m_next = s12_mest_reg;
        end
    end

    // Stage 14: assemble the calendar date
    always_comb
    begin
        dd_full         = s13_j2_reg - month_day_ofs(s13_m_reg);
        k_carry         = (s13_m_reg >= 4'd11);
        yy_full         = 12'(s13_c_reg - 7'd49) * 12'd100 + 12'(s13_y_reg) + 12'(k_carry);
        rsp_next.year   = yy_full;
        rsp_next.month  = k_carry ? (s13_m_reg - 4'd10) : (s13_m_reg + 4'd2);
        rsp_next.day    = dd_full[4:0];
        rsp_next.hour   = s13_hms_reg.hour;
        rsp_next.minute = s13_hms_reg.minute;
        rsp_next.second = s13_hms_reg.second;
    end

    // Hold valid bits; clear on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Advance payload every cycle
    always_ff @(posedge clk)
    begin
        s1_week_reg  <= s1_week_next;
        s1_secs_reg  <= s1_secs_next;

        s2_week_reg  <= s1_week_reg;
        s2_secs_reg  <= s1_secs_reg;
        s2_dq_reg    <= s2_dq_next;

        s3_j0_reg    <= s3_j0_next;
        s3_tod_reg   <= s3_tod_next;

        s4_j0_reg    <= s3_j0_reg;
        s4_cest_reg  <= s4_cest_next;
        s4_tod_reg   <= s3_tod_reg;
        s4_hest_reg  <= s4_hest_next;

        s5_cest_reg  <= s4_cest_reg;
        s5_cr_reg    <= s5_cr_next;
        s5_hest_reg  <= s4_hest_reg;
        s5_hr_reg    <= s5_hr_next;

        s6_c_reg     <= s6_c_next;
        s6_j1_reg    <= s6_j1_next;
        s6_hour_reg  <= s6_hour_next;
        s6_remh_reg  <= s6_remh_next;

        s7_c_reg     <= s6_c_reg;
        s7_j1_reg    <= s6_j1_reg;
        s7_yest_reg  <= s7_yest_next;
        s7_hour_reg  <= s6_hour_reg;
        s7_remh_reg  <= s6_remh_reg;
        s7_mest_reg  <= s7_mest_next;

        s8_c_reg     <= s7_c_reg;
        s8_j1_reg    <= s7_j1_reg;
        s8_yest_reg  <= s7_yest_reg;
        s8_yr_reg    <= s8_yr_next;
        s8_hour_reg  <= s7_hour_reg;
        s8_sr_reg    <= s8_sr_next;
        s8_mest_reg  <= s7_mest_reg;

        s9_c_reg     <= s8_c_reg;
        s9_j1_reg    <= s8_j1_reg;
        s9_y_reg     <= s9_y_next;
        s9_hms_reg   <= s9_hms_next;

        s10_c_reg    <= s9_c_reg;
        s10_y_reg    <= s9_y_reg;
        s10_j2_reg   <= s10_j2_next;
        s10_hms_reg  <= s9_hms_reg;

        s11_c_reg    <= s10_c_reg;
        s11_y_reg    <= s10_y_reg;
        s11_j2_reg   <= s10_j2_reg;
        s11_mest_reg <= s11_mest_next;
        s11_hms_reg  <= s10_hms_reg;

        s12_c_reg    <= s11_c_reg;
        s12_y_reg    <= s11_y_reg;
        s12_j2_reg   <= s11_j2_reg;
        s12_mest_reg <= s11_mest_reg;
        s12_mr_reg   <= s12_mr_next;
        s12_hms_reg  <= s11_hms_reg;

        s13_c_reg    <= s12_c_reg;
        s13_y_reg    <= s12_y_reg;
        s13_j2_reg   <= s12_j2_reg;
        s13_m_reg    <= s13_m_next;
        s13_hms_reg  <= s12_hms_reg;

        rsp_reg      <= rsp_next;
    end

endmodule
